### rtl/core/iafp_pkg.sv
// Shared types and constants for the IMU angle frame parser.
`timescale 1ns / 1ps

package iafp_pkg;

    localparam int FRAME_BYTES = 11;
    localparam int POS_W       = 4;

    localparam logic [7:0] HEADER_BYTE = 8'h55;
    localparam logic [7:0] ANGLE_TYPE  = 8'h53;

    localparam logic [POS_W-1:0] POS_HUNT    = POS_W'(0);
    localparam logic [POS_W-1:0] TYPE_SLOT   = POS_W'(1);
    localparam logic [POS_W-1:0] YAW_LO_SLOT = POS_W'(6);
    localparam logic [POS_W-1:0] YAW_HI_SLOT = POS_W'(7);
    localparam logic [POS_W-1:0] CHECK_SLOT  = POS_W'(FRAME_BYTES - 1);

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_SUM_ERR  = 2'd1,
        STATUS_TYPE_ERR = 2'd2
    } status_t;

    // One completed frame, handed from the tracker to the result buffer.
    typedef struct packed {
        logic               valid;
        status_t            status;
        logic signed [15:0] yaw;
    } result_t;

endpackage

### rtl/core/iafp_if.sv
// Handshake channels for received bytes and frame results.
`timescale 1ns / 1ps

interface iafp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface iafp_result_if
    import iafp_pkg::*;
;
    logic               valid;
    logic               ready;
    status_t            frame_status;
    logic signed [15:0] yaw_raw;

    modport source (output valid, output frame_status, output yaw_raw, input ready);
    modport sink   (input valid, input frame_status, input yaw_raw, output ready);
endinterface

### rtl/core/iafp_frame_tracker.sv
// Frame position, running checksum and captured fields for the byte stream.
`timescale 1ns / 1ps

module iafp_frame_tracker
    import iafp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] rx_byte,
    output result_t    result
);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       sum_reg, sum_next;
    logic [7:0]       type_reg, type_next;
    logic [7:0]       yaw_lo_reg, yaw_lo_next;
    logic [7:0]       yaw_hi_reg, yaw_hi_next;

    always_comb
    begin
        pos_next       = pos_reg;
        sum_next       = sum_reg;
        type_next      = type_reg;
        yaw_lo_next    = yaw_lo_reg;
        yaw_hi_next    = yaw_hi_reg;
        result.valid   = 1'b0;
        result.status  = STATUS_OK;
        result.yaw     = 16'sd0;

        if (accept)
        begin
            if (pos_reg == POS_HUNT)
            begin
                if (rx_byte == HEADER_BYTE)
                begin
                    sum_next = rx_byte;
                    pos_next = TYPE_SLOT;
                end
            end
            else if (pos_reg < CHECK_SLOT)
            begin
                sum_next = sum_reg + rx_byte;
                pos_next = pos_reg + POS_W'(1);
                if (pos_reg == TYPE_SLOT)
                begin
                    type_next = rx_byte;
                end
                else if (pos_reg == YAW_LO_SLOT)
                begin
                    yaw_lo_next = rx_byte;
                end
                else if (pos_reg == YAW_HI_SLOT)
                begin
                    yaw_hi_next = rx_byte;
                end
            end
            else
            begin
                // Checksum byte, or any position past it: the frame ends here.
                result.valid = 1'b1;
                if (sum_reg != rx_byte)
                begin
                    result.status = STATUS_SUM_ERR;
                end
                else if (type_reg != ANGLE_TYPE)
                begin
                    result.status = STATUS_TYPE_ERR;
                end
                else
                begin
                    result.status = STATUS_OK;
                    result.yaw    = signed'({yaw_hi_reg, yaw_lo_reg});
                end
                pos_next = POS_HUNT;
                sum_next = 8'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= POS_HUNT;
            sum_reg    <= 8'd0;
            type_reg   <= 8'd0;
            yaw_lo_reg <= 8'd0;
            yaw_hi_reg <= 8'd0;
        end
        else
        begin
            pos_reg    <= pos_next;
            sum_reg    <= sum_next;
            type_reg   <= type_next;
            yaw_lo_reg <= yaw_lo_next;
            yaw_hi_reg <= yaw_hi_next;
        end
    end

endmodule

### rtl/core/iafp_result_buf.sv
// Output register that holds one frame result until the receiver takes it.
`timescale 1ns / 1ps

module iafp_result_buf
    import iafp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  result_t            result,
    output logic               can_take,
    output logic               valid,
    input  logic               ready,
    output status_t            frame_status,
    output logic signed [15:0] yaw_raw
);

    logic               valid_reg, valid_next;
    status_t            status_reg, status_next;
    logic signed [15:0] yaw_reg, yaw_next;

    // The register frees up in the same cycle its word is taken.
    assign can_take = !valid_reg || ready;

    always_comb
    begin
        valid_next  = valid_reg;
        status_next = status_reg;
        yaw_next    = yaw_reg;
        if (can_take)
        begin
            valid_next = result.valid;
            if (result.valid)
            begin
                status_next = result.status;
                yaw_next    = result.yaw;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        yaw_reg    <= yaw_next;
    end

    assign valid        = valid_reg;
    assign frame_status = status_reg;
    assign yaw_raw      = yaw_reg;

endmodule

### rtl/core/imu_angle_frame_parser_unit.sv
// IMU angle frame parser: serial bytes in, one checked result per frame out.
//
// Channel rx carries one received serial byte per word. The parser drops
// bytes until the 0x55 header, then collects an 11-byte frame while keeping
// an 8-bit running sum of its first ten bytes. The checksum byte completes
// the frame and the parser goes back to hunting for a header.
// Channel res carries one word per completed frame: frame_status (accepted,
// checksum mismatch, or good checksum with a type other than 0x53) and the
// signed little-endian yaw from bytes 6 and 7, zero for a rejected frame.
// Throughput is one byte per cycle while the output register can take a word;
// the single pass of logic between the frame registers and the output register
// sets this figure. A result word appears in the cycle after its checksum byte
// is accepted. When the receiver stalls, the result waits in the output
// register and rx stays ready until that register is full and not being drained.
// Reset clears the frame position and checksum; the parser starts hunting
// and holds no result.
`timescale 1ns / 1ps

module imu_angle_frame_parser_unit
    import iafp_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    iafp_byte_if.sink          rx,
    iafp_result_if.source      res
);

    result_t result;
    logic    can_take;
    logic    accept;

    assign rx.ready = can_take;
    assign accept   = rx.valid && can_take;

    iafp_frame_tracker u_tracker (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (rx.rx_byte),
        .result  (result)
    );

    iafp_result_buf u_result_buf (
        .clk          (clk),
        .rst_n        (rst_n),
        .result       (result),
        .can_take     (can_take),
        .valid        (res.valid),
        .ready        (res.ready),
        .frame_status (res.frame_status),
        .yaw_raw      (res.yaw_raw)
    );

endmodule

### rtl/core/iafp_checker.sv
// Port-level checks for the IMU angle frame parser, bound to the top level.
`timescale 1ns / 1ps

module iafp_checker
    import iafp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        rx_valid,
    input logic        rx_ready,
    input logic        res_valid,
    input logic        res_ready,
    input logic [1:0]  frame_status,
    input logic [15:0] yaw_raw
);

    // A new result word only follows an accepted byte.
    a_result_needs_byte: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(rx_valid && rx_ready))
        else $error("result word appeared without an accepted byte");

    // A full, stalled output register must stop the byte channel.
    a_stall_blocks_rx: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |-> !rx_ready)
        else $error("byte channel ready while result is stalled");

    // A rejected frame reports zero yaw.
    a_reject_zero_yaw: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (frame_status != STATUS_OK) |-> yaw_raw == 16'd0)
        else $error("rejected frame carries nonzero yaw");

    // A stalled result word keeps its payload.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(frame_status)
            && $stable(yaw_raw))
        else $error("stalled result word changed");

endmodule

bind imu_angle_frame_parser_unit iafp_checker u_iafp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .rx_valid     (rx.valid),
    .rx_ready     (rx.ready),
    .res_valid    (res.valid),
    .res_ready    (res.ready),
    .frame_status (res.frame_status),
    .yaw_raw      (res.yaw_raw)
);
